### rtl/core/heightmap_bilinear_sampler_core_macros.svh
// Assertion macros shared by the sampler core.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_CORE_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HBS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sampler check failed");

// Next-cycle implication, checked outside reset.
`define HBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sampler check failed");

`endif

### rtl/core/hbs_pkg.sv
// Types and constants shared by the heightmap sampler modules.
package hbs_pkg;

  localparam int unsigned MAX_SIDE = 256;
  localparam int unsigned SIDE_W   = 9;
  localparam int unsigned CELL_W   = 8;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned FRAC_W   = 17;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  typedef enum logic [2:0] {
    CFG_OFFSET_X,
    CFG_OFFSET_Z,
    CFG_OFFSET_Y,
    CFG_INV_SCALE_X,
    CFG_INV_SCALE_Z,
    CFG_SCALE_Y,
    CFG_GRID_WIDTH,
    CFG_GRID_DEPTH
  } cfg_reg_e;

  typedef struct packed {
    logic [CELL_W-1:0] cell_idx;
    logic [FRAC_W-1:0] frac;
    logic              oob;
  } axis_t;

endpackage

### rtl/core/hbs_axis_map.sv
// Maps one world coordinate to a grid cell and Q1.16 fraction over three stages.
module hbs_axis_map (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [31:0]          pos_i,
  input  logic signed [31:0]          off_i,
  input  logic [31:0]                 inv_i,
  input  logic [hbs_pkg::SIDE_W-1:0]  side_i,
  output hbs_pkg::axis_t              axis_o
);
  import hbs_pkg::*;

  logic [32:0] diff;
  logic        dneg_q;
  logic [31:0] dmag_q;
  logic [63:0] prod_d, prod_q;
  logic        out_d, out_q;
  logic [31:0] hi, sm1;
  logic        edge_hit;
  axis_t       axis_d, axis_q;

  assign diff = {pos_i[31], pos_i} - {off_i[31], off_i};

  always_comb begin
    if (dneg_q) begin
      prod_d = '0;
      out_d  = (inv_i != '0);
    end else begin
      prod_d = 64'(dmag_q) * 64'(inv_i);
      out_d  = 1'b0;
    end
  end

  assign hi       = prod_q[63:32];
  assign sm1      = 32'(side_i) - 32'd1;
  assign edge_hit = (hi == sm1);

  always_comb begin
    axis_d.oob = out_q || (hi > sm1) || (edge_hit && (prod_q[31:0] != '0));
    if (edge_hit) begin
      // last row or column: previous cell at full weight
      axis_d.cell_idx = CELL_W'(side_i - SIDE_W'(2));
      axis_d.frac     = FRAC_ONE;
    end else begin
      axis_d.cell_idx = hi[CELL_W-1:0];
      axis_d.frac     = {1'b0, prod_q[31:16]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dneg_q <= diff[32];
      dmag_q <= diff[31:0];
      prod_q <= prod_d;
      out_q  <= out_d;
      axis_q <= axis_d;
    end
  end

  assign axis_o = axis_q;

endmodule

### rtl/core/hbs_sample_store.sv
// Four copies of the sample grid, one per neighbour, written together.
module hbs_sample_store #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        we_i,
  input  logic [hbs_pkg::ADDR_W-1:0]  widx_i,
  input  logic signed [15:0]          wval_i,
  input  logic [hbs_pkg::CELL_W-1:0]  x_i,
  input  logic [hbs_pkg::CELL_W-1:0]  z_i,
  input  logic [hbs_pkg::SIDE_W-1:0]  width_i,
  output logic signed [15:0]          s_o [4]
);
  import hbs_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [ADDR_W-1:0]      base;
  logic [ADDR_W-1:0]      raddr_q [4];
  logic [ADDR_W-1:0]      waddr_q;
  logic [SAMPLE_BITS-1:0] wdata_q;
  logic                   we_q;
  logic [SAMPLE_BITS-1:0] rdata_q [4];

  assign base = ADDR_W'(z_i) * ADDR_W'(width_i) + ADDR_W'(x_i);

  // we_i marks a write item one stage ahead; it is registered with its data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raddr_q[0] <= base;
      raddr_q[1] <= base + ADDR_W'(width_i);
      raddr_q[2] <= base + ADDR_W'(1);
      raddr_q[3] <= base + ADDR_W'(width_i) + ADDR_W'(1);
      waddr_q    <= widx_i;
      wdata_q    <= SAMPLE_BITS'(wval_i);
      we_q       <= we_i;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [SAMPLE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk_i) begin
      if (en_i && we_q) begin
        mem[waddr_q] <= wdata_q;
      end
      if (en_i) begin
        rdata_q[b] <= mem[raddr_q[b]];
      end
    end

    assign s_o[b] = 16'(signed'(rdata_q[b]));
  end

endmodule

### rtl/core/hbs_blend.sv
// Bilinear weights, blend, vertical scale, offset and saturation.
module hbs_blend (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [hbs_pkg::FRAC_W-1:0]  fx_i,
  input  logic [hbs_pkg::FRAC_W-1:0]  fz_i,
  input  logic                        oob_i,
  input  logic signed [15:0]          s_i [4],
  input  logic signed [31:0]          scale_y_i,
  input  logic signed [31:0]          offset_y_i,
  output logic signed [31:0]          height_o,
  output logic                        in_bounds_o
);
  import hbs_pkg::*;

  logic [FRAC_W-1:0]  gx, gz;
  logic [33:0]        w5_q [4];
  logic [33:0]        w6_q [4];
  logic signed [50:0] p7_q [4];
  logic signed [52:0] sum;
  logic signed [27:0] blend8_q;
  logic [27:0]        bmag9_q;
  logic [31:0]        smag9_q;
  logic               neg9_q, neg10_q;
  logic [59:0]        prod10_q;
  logic               oob5_q, oob6_q, oob7_q, oob8_q, oob9_q, oob10_q;
  logic [43:0]        pmag;
  logic               pneg;
  logic signed [45:0] res;
  logic signed [31:0] height_q;
  logic               inb_q;

  assign gx = FRAC_ONE - fx_i;
  assign gz = FRAC_ONE - fz_i;

  assign sum = 53'(p7_q[0]) + 53'(p7_q[1]) + 53'(p7_q[2]) + 53'(p7_q[3]);

  always_comb begin
    if (oob10_q) begin
      // outside the grid: offset_y minus one
      pmag = 44'h10000;
      pneg = 1'b1;
    end else begin
      pmag = prod10_q[59:16];
      pneg = neg10_q;
    end
    if (pneg) res = 46'(offset_y_i) - signed'({2'b00, pmag});
    else      res = 46'(offset_y_i) + signed'({2'b00, pmag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w5_q[0] <= 34'(gx) * 34'(gz);
      w5_q[1] <= 34'(gx) * 34'(fz_i);
      w5_q[2] <= 34'(fx_i) * 34'(gz);
      w5_q[3] <= 34'(fx_i) * 34'(fz_i);
      oob5_q  <= oob_i;
      w6_q    <= w5_q;
      oob6_q  <= oob5_q;
      for (int i = 0; i < 4; i++) begin
        p7_q[i] <= 51'(signed'({1'b0, w6_q[i]})) * 51'(s_i[i]);
      end
      oob7_q   <= oob6_q;
      blend8_q <= 28'(sum >>> 24);
      oob8_q   <= oob7_q;
      bmag9_q  <= blend8_q[27] ? 28'(-blend8_q) : 28'(blend8_q);
      smag9_q  <= scale_y_i[31] ? 32'(~scale_y_i + 32'sd1) : 32'(scale_y_i);
      neg9_q   <= blend8_q[27] != scale_y_i[31];
      oob9_q   <= oob8_q;
      prod10_q <= 60'(bmag9_q) * 60'(smag9_q);
      neg10_q  <= neg9_q;
      oob10_q  <= oob9_q;
      if (res > 46'sd2147483647)       height_q <= 32'sh7fffffff;
      else if (res < -46'sd2147483648) height_q <= 32'sh80000000;
      else                             height_q <= 32'(res);
      inb_q <= !oob10_q;
    end
  end

  assign height_o    = height_q;
  assign in_bounds_o = inb_q;

endmodule

### rtl/core/heightmap_bilinear_sampler_core.sv
// Heightmap sampler core: writes store Q8.8 samples, queries return a bilinear
// Q16.16 terrain height. One request enters every cycle, writes and queries
// mixed freely; a query result passes the input, axis-map, store and blend
// registers; writes give no result. The rate is set by the sample grid being
// held in four copies, one single-read-port memory per neighbour, all written
// together, so the four corner reads of a query happen in the same cycle. A
// stall on the result side holds the whole pipeline.
`include "heightmap_bilinear_sampler_core_macros.svh"

module heightmap_bilinear_sampler_core #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[31:0], pos_z[63:32], sample_index[79:64], sample_value[95:80]
  input  logic [95:0] s_axis_tdata,
  // func: 0 write, 1 query
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // terrain_height[31:0]
  output logic [31:0] m_axis_tdata,
  // in_bounds
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import hbs_pkg::*;

  localparam int unsigned NS = 11;

  logic signed [31:0] offset_x_q, offset_z_q, offset_y_q, scale_y_q;
  logic [31:0]        inv_scale_x_q, inv_scale_z_q;
  logic [SIDE_W-1:0]  grid_width_q, grid_depth_q;
  logic [SIDE_W-1:0]  side_x, side_z;

  logic               en;
  logic [NS-1:0]      vld_q;
  logic [4:0]         qry_q;
  logic signed [31:0] pos_x_q, pos_z_q;
  logic [ADDR_W-1:0]  idx_q [4];
  logic signed [15:0] val_q [4];
  axis_t              ax, az;
  logic signed [15:0] smp [4];
  logic signed [31:0] height;
  logic               inb;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q    <= '0;
      offset_z_q    <= '0;
      offset_y_q    <= '0;
      inv_scale_x_q <= 32'h10000;
      inv_scale_z_q <= 32'h10000;
      scale_y_q     <= 32'sh10000;
      grid_width_q  <= SIDE_W'(2);
      grid_depth_q  <= SIDE_W'(2);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_OFFSET_X:    offset_x_q    <= cfg_data_i;
        CFG_OFFSET_Z:    offset_z_q    <= cfg_data_i;
        CFG_OFFSET_Y:    offset_y_q    <= cfg_data_i;
        CFG_INV_SCALE_X: inv_scale_x_q <= cfg_data_i;
        CFG_INV_SCALE_Z: inv_scale_z_q <= cfg_data_i;
        CFG_SCALE_Y:     scale_y_q     <= cfg_data_i;
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[SIDE_W-1:0];
        CFG_GRID_DEPTH:  grid_depth_q  <= cfg_data_i[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sides to the supported grid
  always_comb begin
    if (grid_width_q < SIDE_W'(2))             side_x = SIDE_W'(2);
    else if (grid_width_q > SIDE_W'(MAX_SIDE)) side_x = SIDE_W'(MAX_SIDE);
    else                                       side_x = grid_width_q;
    if (grid_depth_q < SIDE_W'(2))             side_z = SIDE_W'(2);
    else if (grid_depth_q > SIDE_W'(MAX_SIDE)) side_z = SIDE_W'(MAX_SIDE);
    else                                       side_z = grid_depth_q;
  end

  assign en            = !vld_q[NS-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      qry_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:5], vld_q[4] && qry_q[4], vld_q[3:0], s_axis_tvalid};
      qry_q <= {qry_q[3:0], s_axis_tuser};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_q  <= s_axis_tdata[31:0];
      pos_z_q  <= s_axis_tdata[63:32];
      idx_q[0] <= s_axis_tdata[79:64];
      val_q[0] <= s_axis_tdata[95:80];
      for (int i = 1; i < 4; i++) begin
        idx_q[i] <= idx_q[i-1];
        val_q[i] <= val_q[i-1];
      end
    end
  end

  hbs_axis_map u_map_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .pos_i  (pos_x_q),
    .off_i  (offset_x_q),
    .inv_i  (inv_scale_x_q),
    .side_i (side_x),
    .axis_o (ax)
  );

  hbs_axis_map u_map_z (
    .clk_i  (clk_i),
    .en_i   (en),
    .pos_i  (pos_z_q),
    .off_i  (offset_z_q),
    .inv_i  (inv_scale_z_q),
    .side_i (side_z),
    .axis_o (az)
  );

  hbs_sample_store #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (en),
    .we_i    (vld_q[3] && !qry_q[3]),
    .widx_i  (idx_q[3]),
    .wval_i  (val_q[3]),
    .x_i     (ax.cell_idx),
    .z_i     (az.cell_idx),
    .width_i (side_x),
    .s_o     (smp)
  );

  hbs_blend u_blend (
    .clk_i       (clk_i),
    .en_i        (en),
    .fx_i        (ax.frac),
    .fz_i        (az.frac),
    .oob_i       (ax.oob || az.oob),
    .s_i         (smp),
    .scale_y_i   (scale_y_q),
    .offset_y_i  (offset_y_q),
    .height_o    (height),
    .in_bounds_o (inb)
  );

  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = height;
  assign m_axis_tuser  = inb;

  `HBS_ASSERT_NXT(a_stall_hold, !en, $stable(vld_q))
  `HBS_ASSERT_NXT(a_write_drop, en && vld_q[4] && !qry_q[4], !vld_q[5])
  `HBS_ASSERT_NXT(a_advance, en && vld_q[NS-2], m_axis_tvalid)
  `HBS_ASSERT(a_side_clamp, 1'b1, side_x >= SIDE_W'(2) && side_z >= SIDE_W'(2))

endmodule
